@@ hdl/pfe_pkg.sv @@
package pfe_pkg;

    localparam int DATA_W              = 32;
    localparam int STACK_DEPTH_DEFAULT = 64;

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;
    localparam logic [7:0] CHAR_PLUS  = 8'h2b;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_STAR  = 8'h2a;
    localparam logic [7:0] CHAR_SLASH = 8'h2f;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_MALFORMED = 2'd1;
    localparam logic [1:0] STATUS_DIVZERO   = 2'd2;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd3;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_expr;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [1:0]               status;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIN
    } t_state;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_TAKE_ABOVE,
        CELL_TAKE_BELOW
    } t_cell_op;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } t_div_rsp;

endpackage

@@ hdl/postfix_expression_evaluator_unit.sv @@
// channel | direction | handshake                  | payload
// input   | in        | i_in_valid / o_in_ready    | i_in_data  (pfe_pkg::t_in_item)
// output  | out       | o_out_valid / i_out_ready  | o_out_data (pfe_pkg::t_out_item)
//
// digits, separators, + - * are taken back to back while idle; '/' holds the input
// until the radix-2 divider, which retires one quotient bit per cycle, is done.
// a transaction marked last passes through the result state to form the result.
// operand stack is a row of STACK_DEPTH shift cells, top of stack in cell 0.
// synchronous active-low reset clears control state; stack cells are not cleared.
// input stalls only during division, the result cycle, or when a last-marked
// transaction arrives while the previous result still waits.
module postfix_expression_evaluator_unit #(
    parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pfe_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pfe_pkg::t_out_item o_out_data
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int DW = pfe_pkg::DATA_W;

    pfe_pkg::t_state    r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [DW-1:0]      r_accum, n_accum;
    logic               r_pend, n_pend;
    logic [1:0]         r_err, n_err;
    logic               r_fin, n_fin;
    logic               r_out_valid, n_out_valid;
    pfe_pkg::t_out_item r_out, n_out;

    logic [DW-1:0]      w_cell [STACK_DEPTH];
    pfe_pkg::t_cell_op  w_op_top, w_op_rest;
    logic [DW-1:0]      w_new_top;

    pfe_pkg::t_div_req  w_div_req;
    pfe_pkg::t_div_rsp  w_div_rsp;

    logic               w_accept;
    logic               w_digit;
    logic               w_oper;
    logic               w_full;
    logic [CW-1:0]      w_count1;
    logic [DW-1:0]      w_a, w_b;
    logic [DW-1:0]      w_prod;
    logic               w_div_go;

    assign o_in_ready = (r_state == pfe_pkg::ST_IDLE)
                     && !(i_in_data.end_of_expr && r_out_valid && !i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_digit  = (i_in_data.char_code >= pfe_pkg::CHAR_ZERO)
                   && (i_in_data.char_code <= pfe_pkg::CHAR_NINE);
    assign w_oper   = (i_in_data.char_code == pfe_pkg::CHAR_PLUS)
                   || (i_in_data.char_code == pfe_pkg::CHAR_MINUS)
                   || (i_in_data.char_code == pfe_pkg::CHAR_STAR)
                   || (i_in_data.char_code == pfe_pkg::CHAR_SLASH);
    assign w_full   = (r_count == CW'(STACK_DEPTH));
    assign w_count1 = r_count + CW'(r_pend);
    assign w_b      = r_pend ? r_accum : w_cell[0];
    assign w_a      = r_pend ? w_cell[0] : w_cell[1];
    assign w_prod   = w_a * w_b;
    assign w_div_go = w_accept && (r_err == pfe_pkg::STATUS_OK) && !w_digit
                   && !(r_pend && w_full)
                   && (i_in_data.char_code == pfe_pkg::CHAR_SLASH)
                   && (w_count1 >= CW'(2)) && (w_b != '0);

    assign w_div_req.start    = w_div_go;
    assign w_div_req.dividend = w_a;
    assign w_div_req.divisor  = w_b;

    pfe_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_top
            pfe_cell u_cell (
                .i_clk   (i_clk),
                .i_op    (w_op_top),
                .i_above (w_new_top),
                .i_below (w_cell[1]),
                .o_value (w_cell[0])
            );
        end else if (g == STACK_DEPTH - 1) begin : g_bottom
            pfe_cell u_cell (
                .i_clk   (i_clk),
                .i_op    (w_op_rest),
                .i_above (w_cell[g-1]),
                .i_below ({DW{1'b0}}),
                .o_value (w_cell[g])
            );
        end else begin : g_mid
            pfe_cell u_cell (
                .i_clk   (i_clk),
                .i_op    (w_op_rest),
                .i_above (w_cell[g-1]),
                .i_below (w_cell[g+1]),
                .o_value (w_cell[g])
            );
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pfe_pkg::ST_IDLE: begin
                if (w_div_go) begin
                    n_state = pfe_pkg::ST_DIV;
                end else if (w_accept && i_in_data.end_of_expr) begin
                    n_state = pfe_pkg::ST_FIN;
                end
            end
            pfe_pkg::ST_DIV: begin
                if (w_div_rsp.done) begin
                    n_state = r_fin ? pfe_pkg::ST_FIN : pfe_pkg::ST_IDLE;
                end
            end
            pfe_pkg::ST_FIN: begin
                n_state = pfe_pkg::ST_IDLE;
            end
            default: begin
                n_state = pfe_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_count     = r_count;
        n_accum     = r_accum;
        n_pend      = r_pend;
        n_err       = r_err;
        n_fin       = r_fin;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        w_op_top    = pfe_pkg::CELL_HOLD;
        w_op_rest   = pfe_pkg::CELL_HOLD;
        w_new_top   = r_accum;
        case (r_state)
            pfe_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_fin = i_in_data.end_of_expr;
                    if (r_err == pfe_pkg::STATUS_OK) begin
                        if (w_digit) begin
                            n_accum = (r_accum << 3) + (r_accum << 1)
                                    + {24'b0, i_in_data.char_code - pfe_pkg::CHAR_ZERO};
                            n_pend  = 1'b1;
                        end else begin
                            n_pend  = 1'b0;
                            n_accum = '0;
                            if (r_pend && w_full) begin
                                n_err = pfe_pkg::STATUS_OVERFLOW;
                            end else if (!w_oper) begin
                                if (r_pend) begin
                                    w_op_top  = pfe_pkg::CELL_TAKE_ABOVE;
                                    w_op_rest = pfe_pkg::CELL_TAKE_ABOVE;
                                    n_count   = r_count + CW'(1);
                                end
                            end else if (w_count1 < CW'(2)) begin
                                n_err = pfe_pkg::STATUS_MALFORMED;
                            end else if (i_in_data.char_code == pfe_pkg::CHAR_SLASH) begin
                                if (w_b == '0) begin
                                    n_err = pfe_pkg::STATUS_DIVZERO;
                                end else if (r_pend) begin
                                    // stack the pending number, quotient replaces both later
                                    w_op_top  = pfe_pkg::CELL_TAKE_ABOVE;
                                    w_op_rest = pfe_pkg::CELL_TAKE_ABOVE;
                                    n_count   = r_count + CW'(1);
                                end
                            end else begin
                                case (i_in_data.char_code)
                                    pfe_pkg::CHAR_PLUS:  w_new_top = w_a + w_b;
                                    pfe_pkg::CHAR_MINUS: w_new_top = w_a - w_b;
                                    default:             w_new_top = w_prod;
                                endcase
                                w_op_top = pfe_pkg::CELL_TAKE_ABOVE;
                                if (r_pend) begin
                                    w_op_rest = pfe_pkg::CELL_HOLD;
                                end else begin
                                    w_op_rest = pfe_pkg::CELL_TAKE_BELOW;
                                    n_count   = r_count - CW'(1);
                                end
                            end
                        end
                    end
                end
            end
            pfe_pkg::ST_DIV: begin
                if (w_div_rsp.done) begin
                    w_new_top = w_div_rsp.quotient;
                    w_op_top  = pfe_pkg::CELL_TAKE_ABOVE;
                    w_op_rest = pfe_pkg::CELL_TAKE_BELOW;
                    n_count   = r_count - CW'(1);
                end
            end
            pfe_pkg::ST_FIN: begin
                n_out.value  = '0;
                n_out.status = pfe_pkg::STATUS_MALFORMED;
                if (r_err != pfe_pkg::STATUS_OK) begin
                    n_out.status = r_err;
                end else if (r_pend) begin
                    if (w_full) begin
                        n_out.status = pfe_pkg::STATUS_OVERFLOW;
                    end else if (r_count == '0) begin
                        n_out.value  = r_accum;
                        n_out.status = pfe_pkg::STATUS_OK;
                    end
                end else if (r_count == CW'(1)) begin
                    n_out.value  = w_cell[0];
                    n_out.status = pfe_pkg::STATUS_OK;
                end
                n_out_valid = 1'b1;
                n_count     = '0;
                n_accum     = '0;
                n_pend      = 1'b0;
                n_err       = pfe_pkg::STATUS_OK;
                n_fin       = 1'b0;
            end
            default: begin
                n_fin = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pfe_pkg::ST_IDLE;
            r_count     <= '0;
            r_accum     <= '0;
            r_pend      <= 1'b0;
            r_err       <= pfe_pkg::STATUS_OK;
            r_fin       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_accum     <= n_accum;
            r_pend      <= n_pend;
            r_err       <= n_err;
            r_fin       <= n_fin;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ hdl/pfe_cell.sv @@
module pfe_cell (
    input  logic                      i_clk,
    input  pfe_pkg::t_cell_op         i_op,
    input  logic [pfe_pkg::DATA_W-1:0] i_above,
    input  logic [pfe_pkg::DATA_W-1:0] i_below,
    output logic [pfe_pkg::DATA_W-1:0] o_value
);

    logic [pfe_pkg::DATA_W-1:0] r_value;
    logic [pfe_pkg::DATA_W-1:0] n_value;

    always_comb begin
        case (i_op)
            pfe_pkg::CELL_TAKE_ABOVE: n_value = i_above;
            pfe_pkg::CELL_TAKE_BELOW: n_value = i_below;
            default:                  n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

@@ hdl/pfe_divider.sv @@
module pfe_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pfe_pkg::t_div_req i_req,
    output pfe_pkg::t_div_rsp o_rsp
);

    logic                        r_busy;
    logic                        r_done;
    logic                        r_neg;
    logic [4:0]                  r_cnt;
    logic [pfe_pkg::DATA_W-1:0]  r_rem;
    logic [pfe_pkg::DATA_W-1:0]  r_quo;
    logic [pfe_pkg::DATA_W-1:0]  r_div;
    logic [pfe_pkg::DATA_W:0]    w_rem_sh;
    logic [pfe_pkg::DATA_W:0]    w_diff;
    logic                        w_fits;

    assign w_rem_sh = {r_rem, r_quo[pfe_pkg::DATA_W-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_div};
    assign w_fits   = w_rem_sh >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == 5'd31);
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == 5'd31)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_neg <= i_req.dividend[pfe_pkg::DATA_W-1] ^ i_req.divisor[pfe_pkg::DATA_W-1];
            r_quo <= i_req.dividend[pfe_pkg::DATA_W-1] ? (~i_req.dividend + 1'b1)
                                                       : i_req.dividend;
            r_div <= i_req.divisor[pfe_pkg::DATA_W-1] ? (~i_req.divisor + 1'b1)
                                                      : i_req.divisor;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_rem <= w_fits ? w_diff[pfe_pkg::DATA_W-1:0] : w_rem_sh[pfe_pkg::DATA_W-1:0];
            r_quo <= {r_quo[pfe_pkg::DATA_W-2:0], w_fits};
            r_cnt <= r_cnt + 5'd1;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_neg ? (~r_quo + 1'b1) : r_quo;

endmodule

@@ hdl/pfe_checker.sv @@
module pfe_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input pfe_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input pfe_pkg::t_out_item o_out_data
);

    // a held result stays put until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed or dropped while stalled");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != pfe_pkg::STATUS_OK) |-> o_out_data.value == '0)
        else $error("nonzero value with error status");

    a_last_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.end_of_expr |=> !o_in_ready)
        else $error("input taken during result cycle");

    a_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready && i_in_data.end_of_expr |-> !o_out_valid || i_out_ready)
        else $error("last transaction accepted with result slot occupied");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind postfix_expression_evaluator_unit pfe_checker u_pfe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

@@ sim/postfix_expression_evaluator_unit_tb.sv @@
module postfix_expression_evaluator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OPERAND_SLOTS = pfe_pkg::STACK_DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS  = 1250;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 40;

    typedef logic [7:0] t_char_q [$];

    class rpn_stack_checker;
        logic [pfe_pkg::DATA_W-1:0] operands [OPERAND_SLOTS];
        int unsigned                depth;
        logic [pfe_pkg::DATA_W-1:0] accum;
        bit                         building;
        logic [1:0]                 fault;
        pfe_pkg::t_out_item         awaited_answers [$];
        int unsigned                failures;

        function new();
            failures = 0;
            restart();
        endfunction

        function void restart();
            depth    = 0;
            accum    = '0;
            building = 1'b0;
            fault    = pfe_pkg::STATUS_OK;
        endfunction

        // only called while no fault is latched
        function void push_operand(logic [pfe_pkg::DATA_W-1:0] v);
            if (depth >= OPERAND_SLOTS) begin
                fault = pfe_pkg::STATUS_OVERFLOW;
            end else begin
                operands[depth] = v;
                depth++;
            end
        endfunction

        function void note_char(pfe_pkg::t_in_item item);
            logic [7:0]                 c;
            logic [pfe_pkg::DATA_W-1:0] lhs;
            logic [pfe_pkg::DATA_W-1:0] rhs;
            logic [pfe_pkg::DATA_W-1:0] mag_l;
            logic [pfe_pkg::DATA_W-1:0] mag_r;
            logic [pfe_pkg::DATA_W-1:0] res;
            pfe_pkg::t_out_item         answer;
            c = item.char_code;
            if (fault == pfe_pkg::STATUS_OK) begin
                if (c >= pfe_pkg::CHAR_ZERO && c <= pfe_pkg::CHAR_NINE) begin
                    accum    = accum * 10 + (c - pfe_pkg::CHAR_ZERO);
                    building = 1'b1;
                end else begin
                    if (building) begin
                        push_operand(accum);
                        building = 1'b0;
                        accum    = '0;
                    end
                    if (fault == pfe_pkg::STATUS_OK) begin
                        case (c)
                            pfe_pkg::CHAR_PLUS, pfe_pkg::CHAR_MINUS,
                            pfe_pkg::CHAR_STAR, pfe_pkg::CHAR_SLASH: begin
                                if (depth < 2) begin
                                    fault = pfe_pkg::STATUS_MALFORMED;
                                end else begin
                                    rhs = operands[depth-1];
                                    lhs = operands[depth-2];
                                    res = '0;
                                    case (c)
                                        pfe_pkg::CHAR_PLUS:  res = lhs + rhs;
                                        pfe_pkg::CHAR_MINUS: res = lhs - rhs;
                                        pfe_pkg::CHAR_STAR:  res = lhs * rhs;
                                        default: begin
                                            if (rhs == '0) begin
                                                fault = pfe_pkg::STATUS_DIVZERO;
                                            end else begin
                                                // truncating signed divide on magnitudes
                                                mag_l = lhs[pfe_pkg::DATA_W-1] ? -lhs : lhs;
                                                mag_r = rhs[pfe_pkg::DATA_W-1] ? -rhs : rhs;
                                                res   = mag_l / mag_r;
                                                if (lhs[pfe_pkg::DATA_W-1]
                                                        != rhs[pfe_pkg::DATA_W-1]) begin
                                                    res = -res;
                                                end
                                            end
                                        end
                                    endcase
                                    if (fault == pfe_pkg::STATUS_OK) begin
                                        depth -= 2;
                                        push_operand(res);
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            if (item.end_of_expr) begin
                if (building && fault == pfe_pkg::STATUS_OK) begin
                    push_operand(accum);
                end
                answer.value  = '0;
                answer.status = fault;
                if (fault == pfe_pkg::STATUS_OK) begin
                    if (depth == 1) begin
                        answer.value = operands[0];
                    end else begin
                        answer.status = pfe_pkg::STATUS_MALFORMED;
                    end
                end
                awaited_answers.push_back(answer);
                restart();
            end
        endfunction

        function void check_answer(pfe_pkg::t_out_item got);
            pfe_pkg::t_out_item want;
            if (awaited_answers.size() == 0) begin
                $display("%0t: unexpected result, expected none, got value %0d status %0d",
                         $time, got.value, got.status);
                failures++;
                return;
            end
            want = awaited_answers.pop_front();
            if (got.value !== want.value) begin
                $display("%0t: value mismatch, expected %0d, got %0d",
                         $time, want.value, got.value);
                failures++;
            end
            if (got.status !== want.status) begin
                $display("%0t: status mismatch, expected %0d, got %0d",
                         $time, want.status, got.status);
                failures++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    pfe_pkg::t_in_item  i_in_data   = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    pfe_pkg::t_out_item o_out_data;

    rpn_stack_checker book;
    int unsigned      in_idle_pct  = 29;
    int unsigned      out_idle_pct = 83;
    int unsigned      chars_sent   = 0;

    string directed_texts [] = '{
        "3 4+", "5 9-", "6 7*", "7 0 2-/", "0 7- 2/", "2147483647 1+",
        "2147483648 0 1-/", "5 0/", "+", "3+", "1 2", " ", "42",
        "99999999999", "5 0/+", "+5 0/", "12 x3,+"
    };

    postfix_expression_evaluator_unit #(
        .STACK_DEPTH(OPERAND_SLOTS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [7:0] random_operator(input bit allow_divide);
        logic [7:0] ops [4];
        ops = '{pfe_pkg::CHAR_PLUS, pfe_pkg::CHAR_MINUS, pfe_pkg::CHAR_STAR,
                pfe_pkg::CHAR_SLASH};
        return ops[$urandom_range(0, allow_divide ? 3 : 2)];
    endfunction

    // any byte that is neither a digit nor an operator
    function automatic logic [7:0] random_separator();
        logic [7:0] c;
        if ($urandom_range(0, 2) != 0) begin
            return " ";
        end
        do begin
            c = 8'($urandom_range(0, 255));
        end while ((c >= pfe_pkg::CHAR_ZERO && c <= pfe_pkg::CHAR_NINE) ||
                   c == pfe_pkg::CHAR_PLUS || c == pfe_pkg::CHAR_MINUS ||
                   c == pfe_pkg::CHAR_STAR || c == pfe_pkg::CHAR_SLASH);
        return c;
    endfunction

    function automatic void add_number(ref t_char_q q, input int unsigned max_digits);
        repeat ($urandom_range(1, max_digits)) begin
            q.push_back(pfe_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
        end
    endfunction

    function automatic t_char_q text_to_chars(input string s);
        t_char_q q;
        for (int i = 0; i < s.len(); i++) begin
            q.push_back(s[i]);
        end
        return q;
    endfunction

    function automatic t_char_q make_expression(input int unsigned serial);
        t_char_q     q;
        int unsigned mode;
        int unsigned operands_left;
        int unsigned depth;
        int unsigned k;
        int unsigned pick;
        mode = $urandom_range(0, 99);
        if (serial % 40 == 7) begin
            // fill the stack around its capacity
            k = $urandom_range(OPERAND_SLOTS - 2, OPERAND_SLOTS + 2);
            for (int i = 0; i < k; i++) begin
                if (i > 0) begin
                    q.push_back(random_separator());
                end
                q.push_back(pfe_pkg::CHAR_ZERO + 8'($urandom_range(1, 9)));
            end
            if ($urandom_range(0, 2) != 0) begin
                repeat (k - 1) q.push_back(random_operator(1'b0));
            end
        end else if (mode < 20) begin
            repeat ($urandom_range(1, 8)) q.push_back(8'($urandom_range(0, 255)));
        end else begin
            operands_left = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20)
                                                        : $urandom_range(1, 5);
            depth = 0;
            while (operands_left > 0 || depth > 1) begin
                if (depth >= 2 && (operands_left == 0 || $urandom_range(0, 1) == 1)) begin
                    if ($urandom_range(0, 3) == 0) begin
                        q.push_back(random_separator());
                    end
                    q.push_back(random_operator(1'b1));
                    depth--;
                end else begin
                    if (q.size() > 0 && q[$] >= pfe_pkg::CHAR_ZERO
                            && q[$] <= pfe_pkg::CHAR_NINE) begin
                        q.push_back(random_separator());
                    end
                    add_number(q, ($urandom_range(0, 3) == 0) ? 12 : 2);
                    depth++;
                    operands_left--;
                end
            end
            if ($urandom_range(0, 4) == 0) begin
                q.push_back(random_separator());
            end
            // broken variants
            if (mode < 35) begin
                pick = $urandom_range(0, q.size() - 1);
                if ($urandom_range(0, 1) == 0) begin
                    q.insert(pick, random_operator(1'b1));
                end else begin
                    q.delete(pick);
                end
            end
        end
        if (q.size() == 0) begin
            q.push_back(" ");
        end
        return q;
    endfunction

    task automatic send_char(input logic [7:0] c, input logic last);
        pfe_pkg::t_in_item item;
        item.char_code   = c;
        item.end_of_expr = last;
        while ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        book.note_char(item);
        chars_sent++;
    endtask

    task automatic send_expression(input t_char_q q);
        for (int i = 0; i < q.size(); i++) begin
            send_char(q[i], i == q.size() - 1);
        end
    endtask

    // result side
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            book.check_answer(o_out_data);
        end
        i_out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end

    // watchdog on cycles without any transaction
    initial begin
        int unsigned stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("Mismatches found");
        $finish;
    end

    initial begin
        t_char_q     q;
        int unsigned first;
        int unsigned serial;
        book = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_texts[i]) begin
            send_expression(text_to_chars(directed_texts[i]));
        end
        q = '{"7", 8'h00, "8", 8'hff, pfe_pkg::CHAR_STAR};
        send_expression(q);

        first  = chars_sent;
        serial = 0;
        while (chars_sent - first < RANDOM_ITEMS) begin
            case ((chars_sent - first) * 3 / RANDOM_ITEMS)
                0: begin
                    in_idle_pct  = 29;
                    out_idle_pct = 83;
                end
                1: begin
                    in_idle_pct  = 83;
                    out_idle_pct = 29;
                end
                default: begin
                    in_idle_pct  = 0;
                    out_idle_pct = 0;
                end
            endcase
            send_expression(make_expression(serial));
            serial++;
        end
        i_in_valid <= 1'b0;

        while (book.awaited_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (book.failures == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
